@@ design/rsi_pkg.sv @@
package rsi_pkg;

  // Default coordinate format: signed Q16.16 in 32 bits
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // Width of the side-band bundle handed from the front end to the back end:
  // miss flag, |d|^2, segment direction, ray start, ray direction, end point A
  function automatic int rsi_sb_width(input int w);
    return 1 + (2 * w + 3) + 2 * (w + 1) + 6 * w;
  endfunction

endpackage

@@ design/ray_segment_intersect_2d_top.sv @@
// 2D ray / line segment intersection in signed fixed point (Q16.16 by default).
// Each request carries the ray start S, ray direction R and segment ends A, B;
// each response says whether the ray meets the segment and, on a hit, the ray
// parameter t (unsigned, saturated) and the hit point (saturated), all zero on
// a miss. The block takes one request per clock while the output is not
// stalled: three front-end stages form side and cos, COORD_WIDTH stages of the
// pipelined restoring divider produce t (the first checks for overflow, each
// later one resolves one quotient bit), and five back-end stages build and
// range-check the hit point. Back-pressure stalls only the stages that are full.
module ray_segment_intersect_2d_top #(
  parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rsi_pkg::FRAC_BITS_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // ray_start_x, ray_start_y, ray_dir_x, ray_dir_y, seg_a_x, seg_a_y, seg_b_x, seg_b_y
  input  logic [8*COORD_WIDTH-1:0]                   s_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // hit_time, hit_x, hit_y
  output logic [((3*COORD_WIDTH-1+7)/8)*8-1:0]       m_axis_tdata,
  // hit
  output logic                                       m_axis_tuser
);
  import rsi_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int SW  = 2 * W + 3;
  localparam int SBW = rsi_sb_width(W);
  localparam int ODW = ((3 * W - 1 + 7) / 8) * 8;

  logic           f_valid, f_ready, d_valid, d_ready;
  logic [SW-1:0]  num, den;
  logic [SBW-1:0] f_sb, d_sb;
  logic [W-2:0]   t;
  logic [W-2:0]   hit_time;
  logic signed [W-1:0] hit_x, hit_y;

  rsi_front #(.W(W)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .ray_start_x_i (s_axis_tdata[0*W +: W]),
    .ray_start_y_i (s_axis_tdata[1*W +: W]),
    .ray_dir_x_i   (s_axis_tdata[2*W +: W]),
    .ray_dir_y_i   (s_axis_tdata[3*W +: W]),
    .seg_a_x_i     (s_axis_tdata[4*W +: W]),
    .seg_a_y_i     (s_axis_tdata[5*W +: W]),
    .seg_b_x_i     (s_axis_tdata[6*W +: W]),
    .seg_b_y_i     (s_axis_tdata[7*W +: W]),
    .out_valid_o   (f_valid),
    .out_ready_i   (f_ready),
    .num_o         (num),
    .den_o         (den),
    .sb_o          (f_sb)
  );

  rsi_div #(.MW(SW), .F(FRAC_BITS), .QW(W - 1), .SBW(SBW)) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .num_i       (num),
    .den_i       (den),
    .sb_i        (f_sb),
    .out_valid_o (d_valid),
    .out_ready_i (d_ready),
    .quo_o       (t),
    .sb_o        (d_sb)
  );

  rsi_back #(.W(W), .F(FRAC_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (d_valid),
    .in_ready_o  (d_ready),
    .t_i         (t),
    .sb_i        (d_sb),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .hit_o       (m_axis_tuser),
    .hit_time_o  (hit_time),
    .hit_x_o     (hit_x),
    .hit_y_o     (hit_y)
  );

  assign m_axis_tdata = ODW'({hit_y, hit_x, hit_time});

endmodule

@@ design/rsi_front.sv @@
module rsi_front #(
  parameter int W = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [W-1:0]                  ray_start_x_i,
  input  logic signed [W-1:0]                  ray_start_y_i,
  input  logic signed [W-1:0]                  ray_dir_x_i,
  input  logic signed [W-1:0]                  ray_dir_y_i,
  input  logic signed [W-1:0]                  seg_a_x_i,
  input  logic signed [W-1:0]                  seg_a_y_i,
  input  logic signed [W-1:0]                  seg_b_x_i,
  input  logic signed [W-1:0]                  seg_b_y_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [2*W+2:0]                       num_o,
  output logic [2*W+2:0]                       den_o,
  output logic [rsi_pkg::rsi_sb_width(W)-1:0] sb_o
);
  import rsi_pkg::*;

  localparam int DW  = W + 1;
  localparam int PW  = 2 * W + 2;
  localparam int SW  = 2 * W + 3;
  localparam int SBW = rsi_sb_width(W);

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  // stage 1: differences
  logic signed [W-1:0]  sx1_q, sy1_q, rx1_q, ry1_q, ax1_q, ay1_q;
  logic signed [DW-1:0] dx1_q, dy1_q, ex1_q, ey1_q;
  // stage 2: products
  logic signed [W-1:0]  sx2_q, sy2_q, rx2_q, ry2_q, ax2_q, ay2_q;
  logic signed [DW-1:0] dx2_q, dy2_q;
  logic signed [PW-1:0] p_dxey_q, p_dyex_q, p_dxry_q, p_dyrx_q, p_dxdx_q, p_dydy_q;
  // stage 3: side, cos, miss decision
  logic signed [SW-1:0] side_d, cos_d, len2_d;
  logic                 miss_d;
  logic [SW-1:0]        num_q, den_q;
  logic [SBW-1:0]       sb_q;

  // stall chain: a stage loads when empty or when its successor moves
  assign en3        = !v3_q || out_ready_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // stage 1
  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      sx1_q <= ray_start_x_i;
      sy1_q <= ray_start_y_i;
      rx1_q <= ray_dir_x_i;
      ry1_q <= ray_dir_y_i;
      ax1_q <= seg_a_x_i;
      ay1_q <= seg_a_y_i;
      dx1_q <= DW'(seg_b_x_i) - DW'(seg_a_x_i);
      dy1_q <= DW'(seg_b_y_i) - DW'(seg_a_y_i);
      ex1_q <= DW'(ray_start_x_i) - DW'(seg_a_x_i);
      ey1_q <= DW'(ray_start_y_i) - DW'(seg_a_y_i);
    end
  end

  // stage 2
  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      sx2_q    <= sx1_q;
      sy2_q    <= sy1_q;
      rx2_q    <= rx1_q;
      ry2_q    <= ry1_q;
      ax2_q    <= ax1_q;
      ay2_q    <= ay1_q;
      dx2_q    <= dx1_q;
      dy2_q    <= dy1_q;
      p_dxey_q <= PW'(dx1_q) * PW'(ey1_q);
      p_dyex_q <= PW'(dy1_q) * PW'(ex1_q);
      p_dxry_q <= PW'(dx1_q) * PW'(ry1_q);
      p_dyrx_q <= PW'(dy1_q) * PW'(rx1_q);
      p_dxdx_q <= PW'(dx1_q) * PW'(dx1_q);
      p_dydy_q <= PW'(dy1_q) * PW'(dy1_q);
    end
  end

  // stage 3: miss if parallel, or if pointing away from the line
  always_comb begin
    side_d = SW'(p_dxey_q) - SW'(p_dyex_q);
    cos_d  = SW'(p_dxry_q) - SW'(p_dyrx_q);
    len2_d = SW'(p_dxdx_q) + SW'(p_dydy_q);
    miss_d = (cos_d == '0) || ((side_d != '0) && (side_d[SW-1] == cos_d[SW-1]));
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      num_q <= side_d[SW-1] ? SW'(-side_d) : SW'(side_d);
      den_q <= cos_d[SW-1] ? SW'(-cos_d) : SW'(cos_d);
      sb_q  <= {miss_d, len2_d, dx2_q, dy2_q, sx2_q, sy2_q, rx2_q, ry2_q, ax2_q, ay2_q};
    end
  end

  assign out_valid_o = v3_q;
  assign num_o       = num_q;
  assign den_o       = den_q;
  assign sb_o        = sb_q;

endmodule

@@ design/rsi_div.sv @@
module rsi_div #(
  parameter int MW  = 67,
  parameter int F   = 16,
  parameter int QW  = 31,
  parameter int SBW = 326
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [MW-1:0]  num_i,
  input  logic [MW-1:0]  den_i,
  input  logic [SBW-1:0] sb_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [QW-1:0]  quo_o,
  output logic [SBW-1:0] sb_o
);

  localparam int RW = MW + F + QW;

  // stage 0 checks for overflow, stage k (1..QW) resolves quotient bit QW-k
  logic [QW:0]    v_q;
  logic [QW+1:0]  en;
  logic [RW-1:0]  rem_q [QW+1];
  logic [MW-1:0]  den_q [QW+1];
  logic [QW-1:0]  quo_q [QW+1];
  logic           sat_q [QW+1];
  logic [SBW-1:0] sb_q  [QW+1];

  assign en[QW+1] = out_ready_i;

  for (genvar s = 0; s <= QW; s++) begin : g_stage
    logic [RW-1:0] rem_in, dsh;
    logic          v_in;

    assign en[s] = !v_q[s] || en[s+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en[s]) begin
        v_q[s] <= v_in;
      end
    end

    if (s == 0) begin : g_first
      // quotient overflows when num * 2^F >= den * 2^QW
      assign v_in   = in_valid_i;
      assign rem_in = RW'(num_i) << F;
      assign dsh    = RW'(den_i) << QW;

      always_ff @(posedge clk_i) begin
        if (en[s] && v_in) begin
          rem_q[s] <= rem_in;
          den_q[s] <= den_i;
          sat_q[s] <= rem_in >= dsh;
          quo_q[s] <= (rem_in >= dsh) ? '1 : '0;
          sb_q[s]  <= sb_i;
        end
      end
    end else begin : g_bit
      // one restoring step per stage
      logic take;
      assign v_in   = v_q[s-1];
      assign rem_in = rem_q[s-1];
      assign dsh    = RW'(den_q[s-1]) << (QW - s);
      assign take   = !sat_q[s-1] && (rem_in >= dsh);

      always_ff @(posedge clk_i) begin
        if (en[s] && v_in) begin
          rem_q[s] <= take ? rem_in - dsh : rem_in;
          den_q[s] <= den_q[s-1];
          sat_q[s] <= sat_q[s-1];
          quo_q[s] <= quo_q[s-1] | (take ? (QW'(1) << (QW - s)) : '0);
          sb_q[s]  <= sb_q[s-1];
        end
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[QW];
  assign quo_o       = quo_q[QW];
  assign sb_o        = sb_q[QW];

endmodule

@@ design/rsi_back.sv @@
module rsi_back #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [W-2:0]                         t_i,
  input  logic [rsi_pkg::rsi_sb_width(W)-1:0] sb_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 hit_o,
  output logic [W-2:0]                         hit_time_o,
  output logic signed [W-1:0]                  hit_x_o,
  output logic signed [W-1:0]                  hit_y_o
);
  import rsi_pkg::*;

  localparam int DW  = W + 1;
  localparam int SW  = 2 * W + 3;
  localparam int OW  = 2 * W;
  localparam int XW  = 2 * W + 1;
  localparam int GW  = 2 * W + 2;
  localparam int QXW = W + 3;
  localparam int MXW = 2 * W + 4;
  localparam int PJW = 2 * W + 5;

  // unpack side band
  logic                 miss_i;
  logic [SW-1:0]        len2_i;
  logic signed [DW-1:0] dx_i, dy_i;
  logic signed [W-1:0]  sx_i, sy_i, rx_i, ry_i, ax_i, ay_i;
  assign {miss_i, len2_i, dx_i, dy_i, sx_i, sy_i, rx_i, ry_i, ax_i, ay_i} = sb_i;

  logic [5:1] v_q;
  logic [6:1] en;

  logic [W-2:0]          t_q   [5:1];
  logic                  miss_q[4:1];
  logic [SW-1:0]         len2_q[4:1];
  logic signed [DW-1:0]  dx_q  [3:1];
  logic signed [DW-1:0]  dy_q  [3:1];
  logic signed [W-1:0]   ax_q  [2:1];
  logic signed [W-1:0]   ay_q  [2:1];
  logic signed [W-1:0]   sx1_q, sy1_q;
  logic signed [OW-1:0]  ox1_q, oy1_q;
  logic signed [XW-1:0]  px2_q, py2_q;
  logic signed [QXW-1:0] qx3_q, qy3_q;
  logic signed [W-1:0]   hx_q [4:3];
  logic signed [W-1:0]   hy_q [4:3];
  logic signed [MXW-1:0] mx4_q, my4_q;
  logic                  hit5_q;
  logic signed [W-1:0]   hx5_q, hy5_q;

  assign en[6] = out_ready_i;
  for (genvar s = 1; s <= 5; s++) begin : g_en
    assign en[s] = !v_q[s] || en[s+1];
  end
  assign in_ready_o = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= in_valid_i;
      if (en[2]) v_q[2] <= v_q[1];
      if (en[3]) v_q[3] <= v_q[2];
      if (en[4]) v_q[4] <= v_q[3];
      if (en[5]) v_q[5] <= v_q[4];
    end
  end

  // stage 1: offsets t * R
  always_ff @(posedge clk_i) begin
    if (en[1] && in_valid_i) begin
      ox1_q     <= OW'($signed({1'b0, t_i})) * OW'(rx_i);
      oy1_q     <= OW'($signed({1'b0, t_i})) * OW'(ry_i);
      sx1_q     <= sx_i;
      sy1_q     <= sy_i;
      ax_q[1]   <= ax_i;
      ay_q[1]   <= ay_i;
      dx_q[1]   <= dx_i;
      dy_q[1]   <= dy_i;
      t_q[1]    <= t_i;
      miss_q[1] <= miss_i;
      len2_q[1] <= len2_i;
    end
  end

  // stage 2: hit point P = S + (t * R) >> F
  always_ff @(posedge clk_i) begin
    if (en[2] && v_q[1]) begin
      px2_q     <= XW'(sx1_q) + XW'(ox1_q >>> F);
      py2_q     <= XW'(sy1_q) + XW'(oy1_q >>> F);
      ax_q[2]   <= ax_q[1];
      ay_q[2]   <= ay_q[1];
      dx_q[2]   <= dx_q[1];
      dy_q[2]   <= dy_q[1];
      t_q[2]    <= t_q[1];
      miss_q[2] <= miss_q[1];
      len2_q[2] <= len2_q[1];
    end
  end

  // stage 3: clamp P - A for the projection, clamp P for the output
  logic signed [GW-1:0] gx_d, gy_d, qlim;
  logic signed [QXW-1:0] qx_d, qy_d;
  logic signed [W-1:0]   hx_d, hy_d;
  logic                  fx, fy;

  assign qlim = GW'(1) << (W + 1);

  always_comb begin
    gx_d = GW'(px2_q) - GW'(ax_q[2]);
    gy_d = GW'(py2_q) - GW'(ay_q[2]);
    if (gx_d > qlim)       qx_d = QXW'(qlim);
    else if (gx_d < -qlim) qx_d = QXW'(-qlim);
    else                   qx_d = QXW'(gx_d);
    if (gy_d > qlim)       qy_d = QXW'(qlim);
    else if (gy_d < -qlim) qy_d = QXW'(-qlim);
    else                   qy_d = QXW'(gy_d);
    // fits when all bits above the sign position agree with the sign bit
    fx   = (px2_q[XW-1:W-1] == '0) || (px2_q[XW-1:W-1] == '1);
    fy   = (py2_q[XW-1:W-1] == '0) || (py2_q[XW-1:W-1] == '1);
    hx_d = fx ? W'(px2_q) : (px2_q[XW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});
    hy_d = fy ? W'(py2_q) : (py2_q[XW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});
  end

  always_ff @(posedge clk_i) begin
    if (en[3] && v_q[2]) begin
      qx3_q     <= qx_d;
      qy3_q     <= qy_d;
      hx_q[3]   <= hx_d;
      hy_q[3]   <= hy_d;
      dx_q[3]   <= dx_q[2];
      dy_q[3]   <= dy_q[2];
      t_q[3]    <= t_q[2];
      miss_q[3] <= miss_q[2];
      len2_q[3] <= len2_q[2];
    end
  end

  // stage 4: projection products
  always_ff @(posedge clk_i) begin
    if (en[4] && v_q[3]) begin
      mx4_q     <= MXW'(dx_q[3]) * MXW'(qx3_q);
      my4_q     <= MXW'(dy_q[3]) * MXW'(qy3_q);
      hx_q[4]   <= hx_q[3];
      hy_q[4]   <= hy_q[3];
      t_q[4]    <= t_q[3];
      miss_q[4] <= miss_q[3];
      len2_q[4] <= len2_q[3];
    end
  end

  // stage 5: range test 0 <= proj <= |d|^2, results zeroed on a miss
  logic signed [PJW-1:0] proj_d;
  logic                  hit_d;

  always_comb begin
    proj_d = PJW'(mx4_q) + PJW'(my4_q);
    hit_d  = !miss_q[4] && !proj_d[PJW-1] && (proj_d <= $signed({2'b00, len2_q[4]}));
  end

  always_ff @(posedge clk_i) begin
    if (en[5] && v_q[4]) begin
      hit5_q <= hit_d;
      t_q[5] <= hit_d ? t_q[4] : '0;
      hx5_q  <= hit_d ? hx_q[4] : '0;
      hy5_q  <= hit_d ? hy_q[4] : '0;
    end
  end

  assign out_valid_o = v_q[5];
  assign hit_o       = hit5_q;
  assign hit_time_o  = t_q[5];
  assign hit_x_o     = hx5_q;
  assign hit_y_o     = hy5_q;

endmodule

@@ design/rsi_checker.sv @@
module rsi_checker #(
  parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 m_axis_tvalid,
  input logic                                 m_axis_tready,
  input logic [((3*COORD_WIDTH-1+7)/8)*8-1:0] m_axis_tdata,
  input logic                                 m_axis_tuser
);
  import rsi_pkg::*;

  localparam int ODW = ((3 * COORD_WIDTH - 1 + 7) / 8) * 8;

  // no response may come out of reset
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("response valid during reset");

  // a miss reports zero time and point
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == ODW'(0)))
    else $error("miss with nonzero payload");

  // stalled response stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("response dropped under stall");

  // stalled response keeps its payload
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("response changed under stall");

endmodule

bind ray_segment_intersect_2d_top rsi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rsi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
